/* rtl/core/uuid_text_parser_core_defines.svh */
// Assertion macros shared by the parser core.
// UUIDP_ASSERT checks a property while reset is released.
// UUIDP_ASSERT_ANY checks a property on every edge, reset included.
`ifndef UUID_TEXT_PARSER_CORE_DEFINES_SVH
`define UUID_TEXT_PARSER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define UUIDP_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("uuid parser assertion failed");
`define UUIDP_ASSERT_ANY(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("uuid parser assertion failed");
`else
`define UUIDP_ASSERT(lbl, clk, rstn, prop)
`define UUIDP_ASSERT_ANY(lbl, clk, prop)
`endif

`endif

/* rtl/core/uuidp_pkg.sv */
package uuidp_pkg;

    localparam int unsigned HEX_DIGITS = 32;
    localparam int unsigned PREFIX_LEN = 9;
    localparam int unsigned ID_BITS    = 128;
    localparam int unsigned FIELD_BITS = 16;
    localparam int unsigned TDATA_BITS = 168;

    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LOW_U  = 8'h75;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_SHORT   = 2'd1,
        ST_INVALID = 2'd2,
        ST_EXCESS  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        PH_LEAD   = 2'd0,
        PH_PREFIX = 2'd1,
        PH_BODY   = 2'd2
    } phase_t;

    typedef struct packed {
        logic       lead_skip;   // dash, space, tab, open brace
        logic       tail_trim;   // dash, space, tab, close brace
        logic       body_pend;   // space, tab, close brace
        logic       dash;
        logic       is_u;
        logic       is_hex;
        logic [3:0] hex_val;
    } char_class_t;

    typedef struct packed {
        status_t                status;
        logic [FIELD_BITS-1:0]  error_position;
        logic [FIELD_BITS-1:0]  found_count;
        logic [63:0]            id_high;
        logic [63:0]            id_low;
    } result_t;

    // Letters of the "urn:uuid:" prefix by index.
    function automatic logic [7:0] prefix_char(input logic [3:0] idx);
        logic [7:0] ch;
        case (idx)
            4'd0:    ch = 8'h75;
            4'd1:    ch = 8'h72;
            4'd2:    ch = 8'h6E;
            4'd3:    ch = 8'h3A;
            4'd4:    ch = 8'h75;
            4'd5:    ch = 8'h75;
            4'd6:    ch = 8'h69;
            4'd7:    ch = 8'h64;
            4'd8:    ch = 8'h3A;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

/* rtl/core/uuidp_char_decode.sv */
module uuidp_char_decode (
    input  logic [7:0]                char_in,
    output uuidp_pkg::char_class_t    cls
);

    logic is_blank;
    logic is_dec;
    logic is_lc;
    logic is_uc;

    assign is_blank = (char_in == uuidp_pkg::CH_SPACE) || (char_in == uuidp_pkg::CH_TAB);
    assign is_dec   = (char_in >= 8'h30) && (char_in <= 8'h39);
    assign is_lc    = (char_in >= 8'h61) && (char_in <= 8'h66);
    assign is_uc    = (char_in >= 8'h41) && (char_in <= 8'h46);

    always_comb begin
        cls.dash      = (char_in == uuidp_pkg::CH_DASH);
        cls.lead_skip = cls.dash || is_blank || (char_in == uuidp_pkg::CH_LBRACE);
        cls.body_pend = is_blank || (char_in == uuidp_pkg::CH_RBRACE);
        cls.tail_trim = cls.dash || cls.body_pend;
        cls.is_u      = (char_in == uuidp_pkg::CH_LOW_U);
        cls.is_hex    = is_dec || is_lc || is_uc;
        // letters: low nibble plus 9 maps a/A to 10
        if (is_dec) begin
            cls.hex_val = char_in[3:0];
        end else begin
            cls.hex_val = char_in[3:0] + 4'd9;
        end
    end

endmodule

/* rtl/core/uuidp_scan.sv */
module uuidp_scan #(
    parameter int unsigned POSITION_BITS = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   step,
    input  logic [7:0]             char_in,
    input  logic                   is_last,
    input  uuidp_pkg::char_class_t cls,
    output uuidp_pkg::result_t     result
);

    localparam int unsigned PB = POSITION_BITS;
    localparam logic [PB-1:0] POS_MAX = {PB{1'b1}};

    uuidp_pkg::phase_t  phase_reg, phase_next;
    logic [3:0]         pidx_reg, pidx_next;
    logic [5:0]         dc_reg, dc_next;
    logic [uuidp_pkg::ID_BITS-1:0] id_reg, id_next;
    logic [PB-1:0]      cp_reg, cp_next;
    logic [PB-1:0]      bs_reg, bs_next;
    logic [PB-1:0]      lk_reg, lk_next;
    uuidp_pkg::status_t ecode_reg, ecode_next;
    logic [PB-1:0]      epos_reg, epos_next;
    logic [PB-1:0]      ppos_reg, ppos_next;
    logic               pvalid_reg, pvalid_next;

    logic [PB-1:0]      cp_inc;
    logic               pfx_hit;
    logic               do_body;
    logic [PB-1:0]      bs_fin;
    logic [PB-1:0]      span;
    logic [PB-1:0]      rpos;
    logic [PB-1:0]      rcount;
    logic [PB+15:0]     rpos_ext;
    logic [PB+15:0]     rcount_ext;

    assign cp_inc  = (cp_reg == POS_MAX) ? POS_MAX : cp_reg + 1'b1;
    assign pfx_hit = (pidx_reg < 4'(uuidp_pkg::PREFIX_LEN))
                     && (char_in == uuidp_pkg::prefix_char(pidx_reg));

    always_comb begin
        phase_next  = phase_reg;
        pidx_next   = pidx_reg;
        dc_next     = dc_reg;
        id_next     = id_reg;
        cp_next     = cp_inc;
        bs_next     = bs_reg;
        lk_next     = lk_reg;
        ecode_next  = ecode_reg;
        epos_next   = epos_reg;
        ppos_next   = ppos_reg;
        pvalid_next = pvalid_reg;
        do_body     = 1'b0;

        if (!cls.tail_trim) begin
            lk_next = cp_inc;
        end

        unique case (phase_reg)
            uuidp_pkg::PH_LEAD: begin
                if (!cls.lead_skip) begin
                    bs_next = cp_reg;
                    if (cls.is_u) begin
                        phase_next = uuidp_pkg::PH_PREFIX;
                        pidx_next  = 4'd1;
                    end else begin
                        phase_next = uuidp_pkg::PH_BODY;
                        do_body    = 1'b1;
                    end
                end
            end
            uuidp_pkg::PH_PREFIX: begin
                if (pfx_hit) begin
                    pidx_next = pidx_reg + 4'd1;
                    if (pidx_next == 4'(uuidp_pkg::PREFIX_LEN)) begin
                        phase_next = uuidp_pkg::PH_BODY;
                        bs_next    = cp_inc;
                    end
                end else begin
                    // broken prefix: fault at the body start, reparse as body
                    if (ecode_next == uuidp_pkg::ST_OK) begin
                        ecode_next = uuidp_pkg::ST_INVALID;
                        epos_next  = bs_reg;
                    end
                    phase_next = uuidp_pkg::PH_BODY;
                    do_body    = 1'b1;
                end
            end
            uuidp_pkg::PH_BODY: begin
                do_body = 1'b1;
            end
            default: begin
                phase_next = phase_reg;
            end
        endcase

        if (do_body) begin
            if (cls.body_pend) begin
                if (!pvalid_reg) begin
                    pvalid_next = 1'b1;
                    ppos_next   = cp_reg;
                end
            end else if (!cls.dash) begin
                // a pending blank was not trailing after all
                if (pvalid_reg) begin
                    pvalid_next = 1'b0;
                    if (ecode_next == uuidp_pkg::ST_OK) begin
                        ecode_next = uuidp_pkg::ST_INVALID;
                        epos_next  = ppos_reg;
                    end
                end
                if (!cls.is_hex) begin
                    if (ecode_next == uuidp_pkg::ST_OK) begin
                        ecode_next = uuidp_pkg::ST_INVALID;
                        epos_next  = cp_reg;
                    end
                end else if (dc_reg[5]) begin
                    if (ecode_next == uuidp_pkg::ST_OK) begin
                        ecode_next = uuidp_pkg::ST_EXCESS;
                        epos_next  = cp_reg;
                    end
                end else begin
                    id_next = {id_reg[uuidp_pkg::ID_BITS-5:0], cls.hex_val};
                    dc_next = dc_reg + 6'd1;
                end
            end
        end

        bs_fin = (phase_next == uuidp_pkg::PH_LEAD) ? cp_inc : bs_next;
        span   = (lk_next > bs_fin) ? lk_next - bs_fin : '0;

        result.id_high = '0;
        result.id_low  = '0;
        if (span < PB'(uuidp_pkg::HEX_DIGITS)) begin
            result.status = uuidp_pkg::ST_SHORT;
            rpos          = bs_fin;
            rcount        = span;
        end else if (ecode_next != uuidp_pkg::ST_OK) begin
            result.status = ecode_next;
            rpos          = epos_next;
            rcount        = '0;
        end else if (!dc_next[5]) begin
            result.status = uuidp_pkg::ST_SHORT;
            rpos          = lk_next;
            rcount        = PB'(dc_next);
        end else begin
            result.status  = uuidp_pkg::ST_OK;
            rpos           = '0;
            rcount         = '0;
            result.id_high = id_next[127:64];
            result.id_low  = id_next[63:0];
        end
        rpos_ext              = {16'd0, rpos};
        rcount_ext            = {16'd0, rcount};
        result.error_position = rpos_ext[15:0];
        result.found_count    = rcount_ext[15:0];

        // the final character returns all control state to the idle state
        if (is_last) begin
            phase_next  = uuidp_pkg::PH_LEAD;
            pidx_next   = '0;
            dc_next     = '0;
            cp_next     = '0;
            bs_next     = '0;
            lk_next     = '0;
            ecode_next  = uuidp_pkg::ST_OK;
            epos_next   = '0;
            ppos_next   = '0;
            pvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= uuidp_pkg::PH_LEAD;
            pidx_reg   <= '0;
            dc_reg     <= '0;
            cp_reg     <= '0;
            bs_reg     <= '0;
            lk_reg     <= '0;
            ecode_reg  <= uuidp_pkg::ST_OK;
            epos_reg   <= '0;
            ppos_reg   <= '0;
            pvalid_reg <= 1'b0;
        end else if (step) begin
            phase_reg  <= phase_next;
            pidx_reg   <= pidx_next;
            dc_reg     <= dc_next;
            cp_reg     <= cp_next;
            bs_reg     <= bs_next;
            lk_reg     <= lk_next;
            ecode_reg  <= ecode_next;
            epos_reg   <= epos_next;
            ppos_reg   <= ppos_next;
            pvalid_reg <= pvalid_next;
        end
    end

    // digit shifter holds no control state
    always_ff @(posedge aclk) begin
        if (step) begin
            id_reg <= id_next;
        end
    end

endmodule

/* rtl/core/uuid_text_parser_core.sv */
// UUID text parser core.
// Slave channel: one text character per item; s_tlast marks the final one.
// Master channel: one result item per text, sent after its final character:
// status, error position, found count and the 128-bit identifier.
// Leading dashes, blanks and an open brace are skipped, then an optional
// "urn:uuid:" prefix; trailing dashes, blanks and a close brace are trimmed.
// Throughput: one character per clock unless a final character must wait.
// The final character lands in the input register when accepted, and its
// result lands in the result register once that register is free, so
// m_tvalid rises once the result register has been loaded.
// Each character is decoded and folded into the scan state
// between the input register and the result register.
// Reset (aresetn low, synchronous) empties both registers and returns the
// scan state to the leading-skip phase; the next character starts a new text.
// When the receiver stalls, the result register holds its item; plain
// characters keep flowing, and only a final character waits until the
// result register is free; while it waits, s_tready drops as well.
`include "uuid_text_parser_core_defines.svh"

module uuid_text_parser_core #(
    parameter int unsigned POSITION_BITS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,

    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] char_in
    input  logic         s_tlast,   // is_last

    output logic         m_tvalid,
    input  logic         m_tready,
    // [1:0] status, [17:2] error_position, [33:18] found_count,
    // [97:34] id_high, [161:98] id_low, [167:162] zero
    output logic [uuidp_pkg::TDATA_BITS-1:0] m_tdata
);

    logic                   in_valid_reg;
    logic [7:0]             in_char_reg;
    logic                   in_last_reg;
    logic                   out_valid_reg;
    uuidp_pkg::result_t     out_res_reg;

    logic                   out_free;
    logic                   advance;
    logic                   s_accept;
    uuidp_pkg::char_class_t cls;
    uuidp_pkg::result_t     scan_res;

    // A plain character always advances; a final one needs a free result slot.
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && (!in_last_reg || out_free);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    // Input register: hold the character until the scan takes it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_accept) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_char_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    uuidp_char_decode u_decode (
        .char_in (in_char_reg),
        .cls     (cls)
    );

    uuidp_scan #(
        .POSITION_BITS (POSITION_BITS)
    ) u_scan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .char_in (in_char_reg),
        .is_last (in_last_reg),
        .cls     (cls),
        .result  (scan_res)
    );

    // Result register: load on the final character, drop once taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && in_last_reg) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_last_reg) begin
            out_res_reg <= scan_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0,
                       out_res_reg.id_low,
                       out_res_reg.id_high,
                       out_res_reg.found_count,
                       out_res_reg.error_position,
                       out_res_reg.status};

    // The result register is empty right after reset.
    `UUIDP_ASSERT_ANY(a_empty_after_reset, aclk, !aresetn |=> !m_tvalid)
    // A success carries no position and no count.
    `UUIDP_ASSERT(a_ok_clean, aclk, aresetn,
        m_tvalid && (out_res_reg.status == uuidp_pkg::ST_OK)
        |-> (out_res_reg.error_position == '0) && (out_res_reg.found_count == '0))
    // A failure carries a zero identifier.
    `UUIDP_ASSERT(a_fail_zero_id, aclk, aresetn,
        m_tvalid && (out_res_reg.status != uuidp_pkg::ST_OK)
        |-> (out_res_reg.id_high == '0) && (out_res_reg.id_low == '0))
    // A character the scan cannot take stays in the input register.
    `UUIDP_ASSERT(a_input_held, aclk, aresetn,
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_char_reg))

endmodule
